@@ rtl/npsf_pkg.sv @@
// shared types and constants for the next prime sieve finder
package npsf_pkg;

    // width of the start value and of the returned prime
    localparam int VALUE_W = 17;

    // sequencer states: build the map after reset, then serve queries
    typedef enum logic [3:0] {
        S_FILL,
        S_TEST_RD,
        S_TEST,
        S_CLR_RD,
        S_CLR_WR,
        S_INC_I,
        S_INC_SQ,
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DONE
    } state_t;

    // bitmap memory strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

@@ rtl/npsf_map_ram.sv @@
// single-port bitmap memory with registered read data
module npsf_map_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  logic                  clk,
    input  npsf_pkg::ram_ctl_t    ctl,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [DATA_W-1:0]     wdata,
    output logic [DATA_W-1:0]     rdata
);
    import npsf_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/npsf_alu.sv @@
// shared adder with limit compare used by the sequencer's counting and compare steps
module npsf_alu #(
    parameter int CW = 18
) (
    input  logic [CW-1:0] a,
    input  logic [CW-1:0] b,
    input  logic [CW-1:0] lim,
    output logic [CW-1:0] sum,
    output logic          ge
);
    import npsf_pkg::*;

    assign sum = a + b;
    assign ge  = (sum >= lim);

endmodule

@@ rtl/next_prime_sieve_finder_unit.sv @@
// top level: odd-only sieve bitmap built after reset, next odd prime lookup per query
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+-----------------------------
//  query   | in_valid / in_ready             | in        | start_value[16:0]
//  answer  | out_valid / out_ready           | out       | prime_value[16:0], found
//
//  after reset the bitmap memory is filled with ones, one word a cycle (MAP_WORDS words,
//  2048 at the default size), then sieved: per candidate up to the square root of the
//  map range a read, a test and the steps of i and p*p, and per cleared bit a read and
//  a write back; in_ready stays low until the sieve is done
//  a query reads and checks the start word, then one further word at a time until a hit
//  or the end of the map; each word takes its own read on the single bitmap memory port
//  a finished answer sits in the output register, so the next query transfer is taken
//  while out_ready is low; a second answer waits in the done state until the first leaves
//  WORD_WIDTH must be a power of two
module next_prime_sieve_finder_unit #(
    parameter int ODD_COUNT  = 65536,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [npsf_pkg::VALUE_W-1:0]  start_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [npsf_pkg::VALUE_W-1:0]  prime_value,
    output logic                          found
);
    import npsf_pkg::*;

    // map geometry
    localparam int MAP_WORDS = (ODD_COUNT + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_WIDTH);
    // index width: room for sums up to four times the map size and for start_value / 2
    localparam int CW0       = $clog2(ODD_COUNT) + 2;
    localparam int CW        = (CW0 > VALUE_W + 1) ? CW0 : VALUE_W + 1;
    localparam int LAST_BITS = ODD_COUNT - (MAP_WORDS - 1) * WORD_WIDTH;

    localparam logic [WORD_WIDTH-1:0] ONES      = {WORD_WIDTH{1'b1}};
    localparam logic [WORD_WIDTH-1:0] LAST_MASK = ONES >> (WORD_WIDTH - LAST_BITS);
    localparam logic [WA-1:0]         LAST_WORD = WA'(MAP_WORDS - 1);
    localparam logic [CW-1:0]         ODD_LIM   = CW'(ODD_COUNT);
    localparam logic [CW-1:0]         WORDS_LIM = CW'(MAP_WORDS);
    localparam logic [CW-1:0]         WORD_STEP = CW'(WORD_WIDTH);
    localparam logic [CW-1:0]         ONE       = CW'(1);
    // first multiple to clear for the prime 3 is 9, bit (9 - 1) / 2
    localparam logic [CW-1:0]         FIRST_SQ  = CW'(4);

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] i_reg;       // sieve candidate index, fill word counter before that
    logic [CW-1:0] sq_reg;      // bit index of p*p for p = 2i+1
    logic [CW-1:0] j_reg;       // bit index of the multiple being cleared
    logic          out_valid_reg;

    // query datapath
    logic [CW-1:0]          idx_reg;
    logic                   hit_reg;
    logic [VALUE_W-1:0]     prime_reg;
    logic                   found_reg;

    // shared adder
    logic [CW-1:0] alu_a, alu_b, alu_lim, alu_sum;
    logic          alu_ge;

    // bitmap memory
    ram_ctl_t              ram_ctl;
    logic [WA-1:0]         ram_addr;
    logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

    // sieve step and word scan helpers
    logic [CW-1:0]         step;
    logic [WORD_WIDTH-1:0] cand;
    logic                  cand_hit;
    logic [BW-1:0]         cand_pos;
    logic                  out_free;
    logic                  in_xfer;

    assign step     = {i_reg[CW-2:0], 1'b1};
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    npsf_alu #(
        .CW(CW)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .lim (alu_lim),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    npsf_map_ram #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (WA),
        .DATA_W (WORD_WIDTH)
    ) u_map_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // operand select for the shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_lim = ODD_LIM;
        case (state_reg)
            S_FILL:
            begin
                alu_a   = i_reg;
                alu_b   = ONE;
                alu_lim = WORDS_LIM;
            end
            S_CLR_WR:
            begin
                alu_a = j_reg;
                alu_b = step;
            end
            S_INC_I:
            begin
                alu_a = i_reg;
                alu_b = ONE;
            end
            S_INC_SQ:
            begin
                // (p+2)^2 bit index grows by 4(i+1); i already holds i+1 here
                alu_a = sq_reg;
                alu_b = {i_reg[CW-3:0], 2'b00};
            end
            S_SRCH_RD:
            begin
                // compare only: is the search index past the end of the map
                alu_a = idx_reg;
                alu_b = '0;
            end
            S_SRCH_CHK:
            begin
                // start of the next word
                alu_a = {idx_reg[CW-1:BW], {BW{1'b0}}};
                alu_b = WORD_STEP;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // memory port select
    always_comb
    begin
        ram_ctl   = '0;
        ram_addr  = '0;
        ram_wdata = ONES;
        case (state_reg)
            S_FILL:
            begin
                // the number 1 is not prime
                ram_ctl.wr_en = 1'b1;
                ram_addr      = i_reg[WA-1:0];
                ram_wdata     = (i_reg == '0) ? (ONES << 1) : ONES;
            end
            S_TEST_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                ram_addr      = i_reg[BW+WA-1:BW];
            end
            S_CLR_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                ram_addr      = j_reg[BW+WA-1:BW];
            end
            S_CLR_WR:
            begin
                ram_ctl.wr_en = 1'b1;
                ram_addr      = j_reg[BW+WA-1:BW];
                ram_wdata     = ram_rdata & ~({{(WORD_WIDTH-1){1'b0}}, 1'b1} << j_reg[BW-1:0]);
            end
            S_SRCH_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                ram_addr      = idx_reg[BW+WA-1:BW];
            end
            default:
            begin
                ram_ctl = '0;
            end
        endcase
    end

    // candidates in the fetched word: at or above the start bit, inside the map
    always_comb
    begin
        cand = ram_rdata & (ONES << idx_reg[BW-1:0]);
        if (idx_reg[BW+WA-1:BW] == LAST_WORD)
        begin
            cand = cand & LAST_MASK;
        end
        cand_hit = |cand;
        cand_pos = '0;
        for (int b = WORD_WIDTH - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                cand_pos = BW'(b);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:
            begin
                if (alu_ge)
                begin
                    state_next = S_TEST_RD;
                end
            end
            S_TEST_RD:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (ram_rdata[i_reg[BW-1:0]])
                begin
                    state_next = S_CLR_RD;
                end
                else
                begin
                    state_next = S_INC_I;
                end
            end
            S_CLR_RD:
            begin
                state_next = S_CLR_WR;
            end
            S_CLR_WR:
            begin
                if (alu_ge)
                begin
                    state_next = S_INC_I;
                end
                else
                begin
                    state_next = S_CLR_RD;
                end
            end
            S_INC_I:
            begin
                state_next = S_INC_SQ;
            end
            S_INC_SQ:
            begin
                // once p*p is past the map every composite has been cleared
                if (alu_ge)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_TEST_RD;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (alu_ge)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (cand_hit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            i_reg         <= '0;
            sq_reg        <= FIRST_SQ;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_FILL:
                begin
                    if (alu_ge)
                    begin
                        i_reg  <= ONE;
                        sq_reg <= FIRST_SQ;
                    end
                    else
                    begin
                        i_reg <= alu_sum;
                    end
                end
                S_TEST:
                begin
                    // multiples below p*p already went with smaller primes
                    j_reg <= sq_reg;
                end
                S_CLR_WR:
                begin
                    j_reg <= alu_sum;
                end
                S_INC_I:
                begin
                    i_reg <= alu_sum;
                end
                S_INC_SQ:
                begin
                    sq_reg <= alu_sum;
                end
                default:
                begin
                    j_reg <= j_reg;
                end
            endcase

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // query payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            // rounding up to odd and halving is a plain shift
            idx_reg <= CW'(start_value[VALUE_W-1:1]);
        end
        if (state_reg == S_SRCH_RD && alu_ge)
        begin
            hit_reg <= 1'b0;
        end
        if (state_reg == S_SRCH_CHK)
        begin
            if (cand_hit)
            begin
                idx_reg <= {idx_reg[CW-1:BW], cand_pos};
                hit_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= alu_sum;
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            prime_reg <= hit_reg ? {idx_reg[VALUE_W-2:0], 1'b1} : '0;
            found_reg <= hit_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prime_value = prime_reg;
    assign found       = found_reg;

    // a miss always reports zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> prime_value == '0)
        else $error("miss with nonzero prime value");

    // a hit is always odd
    a_hit_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> prime_value[0])
        else $error("even prime value reported");

    // the bitmap is only written while it is being built
    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.wr_en |-> (state_reg == S_FILL || state_reg == S_CLR_WR))
        else $error("bitmap written outside the sieve");

    // sieve clears stay inside the map and never reach the prime itself
    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR_WR |-> (j_reg < ODD_LIM && j_reg > i_reg))
        else $error("sieve clear out of range");

    // a query transfer starts a word fetch
    a_query_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_SRCH_RD)
        else $error("query transfer did not start a search");

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the next prime sieve finder: random and directed queries
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npsf_pkg::*;

    // map geometry, kept at the block's defaults
    localparam int ODD_COUNT      = 65536;
    localparam int WORD_WIDTH     = 32;
    localparam int VALUE_MAX      = (1 << VALUE_W) - 1;
    // range of values covered by one map word
    localparam int WORD_SPAN      = 2 * WORD_WIDTH;
    localparam int RANDOM_QUERIES = 1400;
    // a few words of scanning plus the output register, with margin
    localparam int DRAIN_CYCLES   = 64;
    localparam int REPORT_LIMIT   = 20;

    // corner starts: zero and one, small evens and odds, word edges, long prime gaps,
    // alternating bit patterns and the top of the value range
    localparam int DIRECTED_N = 24;
    localparam int DIRECTED_STARTS [DIRECTED_N] = '{
        0, 1, 2, 3, 4, 5, 8, 9, 62, 63, 64, 65,
        1328, 1360, 31398, 31468, 65535, 65536, 87381, 43690,
        131068, 131069, 131070, 131071
    };

    // primes followed by long gaps in range, so searches can cross map words
    localparam int GAP_PRIMES [6] = '{113, 1327, 9551, 15683, 19609, 31397};

    typedef struct packed {
        logic [VALUE_W-1:0] prime;
        logic               hit;
    } answer_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               out_ready   = 1'b0;
    logic [VALUE_W-1:0] start_value = '0;
    logic               in_ready;
    logic               out_valid;
    logic [VALUE_W-1:0] prime_value;
    logic               found;

    // local odd-only sieve: entry i set when 2i+1 is prime
    bit odd_prime_bits [ODD_COUNT];

    // starts waiting to be driven, answers waiting to come back
    logic [VALUE_W-1:0] query_q [$];
    answer_t            answer_q [$];

    int burst_left    = 0;
    int gap_left      = 0;
    int stall_cycle   = 0;
    int queries_sent  = 0;
    int answers_seen  = 0;
    int error_count   = 0;
    int widest_step   = 0;
    int even_starts   = 0;
    int word_crossing = 0;

    next_prime_sieve_finder_unit #(
        .ODD_COUNT  (ODD_COUNT),
        .WORD_WIDTH (WORD_WIDTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_value (start_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .prime_value (prime_value),
        .found       (found)
    );

    always #2 clk = ~clk;

    // classic sieve over odd numbers, striking odd multiples from p*p upward
    function automatic void build_odd_sieve();
        int p;
        int m;
        foreach (odd_prime_bits[i])
            odd_prime_bits[i] = 1'b1;
        odd_prime_bits[0] = 1'b0;
        for (p = 3; p * p < 2 * ODD_COUNT; p += 2)
        begin
            if (odd_prime_bits[p >> 1])
            begin
                for (m = p * p; m < 2 * ODD_COUNT; m += 2 * p)
                    odd_prime_bits[m >> 1] = 1'b0;
            end
        end
    endfunction

    // round the start up to odd and walk the map to the first set entry
    function automatic answer_t lookup_next_prime(logic [VALUE_W-1:0] start);
        answer_t ans;
        int      idx;
        ans = '0;
        for (idx = (int'(start) | 1) >> 1; idx < ODD_COUNT; idx++)
        begin
            if (odd_prime_bits[idx])
            begin
                ans.prime = VALUE_W'(2 * idx + 1);
                ans.hit   = 1'b1;
                return ans;
            end
        end
        return ans;
    endfunction

    // idle stretch after a burst: often none, mostly short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        if (r < 8)
            return $urandom_range(1, 4);
        return $urandom_range(5, 30);
    endfunction

    // random start, weighted toward the interesting regions of the map
    function automatic logic [VALUE_W-1:0] pick_start();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            v = $urandom_range(0, VALUE_MAX);
        else if (sel == 5)
            v = $urandom_range(0, 300);
        else if (sel == 6)
            v = $urandom_range(VALUE_MAX - 400, VALUE_MAX);
        else if (sel < 9)
            v = GAP_PRIMES[$urandom_range(0, 5)] + $urandom_range(0, 72);
        else
            v = $urandom_range(0, ODD_COUNT / WORD_WIDTH - 1) * WORD_SPAN
                + $urandom_range(0, 3) - 2;
        return VALUE_W'(v);
    endfunction

    // driver: bursts of back-to-back transfers with random gaps between them,
    // and the expected answer is worked out on each accepted transfer
    always @(posedge clk)
    begin
        answer_t want;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                want = lookup_next_prime(start_value);
                answer_q.push_back(want);
                queries_sent++;
                if (!start_value[0])
                    even_starts++;
                if (want.hit && int'(want.prime) - int'(start_value) > widest_step)
                    widest_step = int'(want.prime) - int'(start_value);
                if (want.hit && (want.prime / WORD_SPAN) != (start_value / WORD_SPAN))
                    word_crossing++;
            end
            // load the next start only once the current one has gone
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || query_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    in_valid    <= 1'b1;
                    start_value <= query_q.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= pick_gap();
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver backpressure: cycles through always ready, light stalls,
    // heavy stalls and a fixed on/off pattern in turn
    always @(posedge clk)
    begin
        logic [15:0] stall_pattern;
        stall_pattern = 16'b1110_0011_0101_1000;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            case ((stall_cycle >> 8) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= stall_pattern[stall_cycle % 16];
            endcase
            stall_cycle++;
        end
    end

    // monitor: every answer transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (answer_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected answer prime_value=%0d found=%0b",
                             $realtime, prime_value, found);
            end
            else
            begin
                want = answer_q.pop_front();
                answers_seen++;
                if (prime_value !== want.prime)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: prime_value expected %0d actual %0d",
                                 $realtime, want.prime, prime_value);
                end
                if (found !== want.hit)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: found expected %0b actual %0b",
                                 $realtime, want.hit, found);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int n;
        build_odd_sieve();
        for (n = 0; n < DIRECTED_N; n++)
            query_q.push_back(VALUE_W'(DIRECTED_STARTS[n]));
        for (n = 0; n < RANDOM_QUERIES; n++)
            query_q.push_back(pick_start());

        // the block builds its map after this, with in_ready low until done
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (query_q.size() != 0 || in_valid || answer_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (answer_q.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d answers never arrived", $realtime, answer_q.size());
        end

        $display("%0d queries sent, %0d answers checked, %0d even starts",
                 queries_sent, answers_seen, even_starts);
        $display("widest step to a prime %0d, %0d searches crossed a map word",
                 widest_step, word_crossing);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog: the sieve build takes far longer than the queries
    initial
    begin
        #6_000_000;
        $display("%0t: timeout with %0d answers outstanding", $realtime, answer_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/npsf_pkg.sv
rtl/npsf_map_ram.sv
rtl/npsf_alu.sv
rtl/next_prime_sieve_finder_unit.sv
dv/tb.sv
